@@ hdl/cmt_pkg.sv @@
package cmt_pkg;

    // request kinds carried in tuser
    localparam logic REQ_JOIN  = 1'b0;
    localparam logic REQ_LEAVE = 1'b1;

    // capacity register
    localparam int         CAP_W     = 7;
    localparam logic [6:0] CAP_RESET = 7'd64;

    // input tdata layout, lowest bit up
    localparam int IN_CL_LSB   = 0;
    localparam int IN_NODE_LSB = 8;
    localparam int IN_SLOT_LSB = 40;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 8;

    // controller -> datapath
    typedef struct packed {
        logic clear;        // clearing pass: zero one count entry
        logic accept;       // capture request, read count
        logic rd_members;   // read slot and tail entries
        logic emit;         // load result register
        logic emit_ok;      // result value
        logic commit_join;  // append node, count + 1
        logic commit_leave; // move tail into slot, count - 1
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic clear_done;
        logic is_leave;
        logic join_ok;
        logic slot_ok;
        logic id_match;
        logic out_free;
    } t_status;

endpackage

@@ hdl/cmt_ctrl.sv @@
module cmt_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  cmt_pkg::t_status i_sts,
    output cmt_pkg::t_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_EVAL  = 4'b0100,
        S_CHECK = 4'b1000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clear_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_s_tready   = 1'b1;
                o_cmd.accept = i_s_tvalid;
                if (i_s_tvalid) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (i_sts.is_leave && i_sts.slot_ok) begin
                    // occupied slot: fetch slot and tail, check next cycle
                    o_cmd.rd_members = 1'b1;
                    n_state          = S_CHECK;
                end else if (i_sts.out_free) begin
                    o_cmd.emit        = 1'b1;
                    o_cmd.emit_ok     = i_sts.join_ok && !i_sts.is_leave;
                    o_cmd.commit_join = i_sts.join_ok && !i_sts.is_leave;
                    n_state           = S_IDLE;
                end
            end
            S_CHECK: begin
                if (i_sts.out_free) begin
                    o_cmd.emit         = 1'b1;
                    o_cmd.emit_ok      = i_sts.id_match;
                    o_cmd.commit_leave = i_sts.id_match;
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    a_emit_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_sts.out_free)
        else $error("result loaded while output register busy");

    a_one_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.commit_join && o_cmd.commit_leave) && !(o_cmd.clear && o_cmd.emit))
        else $error("conflicting memory commands");

    a_accept_to_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> (r_state == S_EVAL))
        else $error("accepted item not evaluated");

    a_read_to_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.rd_members |=> (r_state == S_CHECK) && !o_s_tready)
        else $error("member read not followed by check");

endmodule

@@ hdl/cmt_datapath.sv @@
module cmt_datapath #(
    parameter int CLUSTER_CNT = 256,
    parameter int MAX_MEMBERS = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [cmt_pkg::IN_TDATA_W-1:0]      i_s_tdata,
    input  logic                                i_s_tuser,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [cmt_pkg::OUT_TDATA_W-1:0]     o_m_tdata,
    input  logic                                i_cfg_wr_en,
    input  logic [cmt_pkg::CAP_W-1:0]           i_cfg_wr_data,
    input  cmt_pkg::t_cmd                       i_cmd,
    output cmt_pkg::t_status                    o_sts
);

    // only 256 clusters can be named by an 8-bit id
    localparam int CD  = (CLUSTER_CNT < 256) ? CLUSTER_CNT : 256;
    localparam int CIW = (CD > 1) ? $clog2(CD) : 1;
    localparam int SW  = (MAX_MEMBERS > 1) ? $clog2(MAX_MEMBERS) : 1;
    localparam int CW  = $clog2(MAX_MEMBERS + 1);
    localparam int W   = (CW > cmt_pkg::CAP_W) ? CW : cmt_pkg::CAP_W;
    localparam int AW  = CIW + SW;
    localparam int MD  = CD * (2 ** SW);

    logic [cmt_pkg::CAP_W-1:0] r_cap;
    logic [CIW-1:0]            r_clr_idx;
    logic                      r_type;
    logic [7:0]                r_cl;
    logic [31:0]               r_node;
    logic [5:0]                r_slot;
    logic [CW-1:0]             r_cnt_q;
    logic [31:0]               r_slot_q;
    logic [31:0]               r_tail_q;
    logic                      r_out_valid;
    logic                      r_out_ok;

    logic [CW-1:0] cnt_mem [CD];
    logic [31:0]   mem_mem [MD];

    logic [7:0]    in_cl;
    logic [CIW-1:0] cl_idx;
    logic [SW-1:0] slot_sw;
    logic [SW-1:0] tail_sw;
    logic          in_range;
    logic          cnt_we;
    logic [CIW-1:0] cnt_wa;
    logic [CW-1:0] cnt_wd;
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [31:0]   mem_wd;

    assign in_cl   = i_s_tdata[cmt_pkg::IN_CL_LSB +: 8];
    assign cl_idx  = CIW'(r_cl);
    assign slot_sw = SW'(r_slot);
    assign tail_sw = SW'(r_cnt_q - CW'(1));
    assign in_range = 17'(r_cl) < 17'(CLUSTER_CNT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= cmt_pkg::CAP_RESET;
        end else if (i_cfg_wr_en) begin
            r_cap <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx <= '0;
        end else if (i_cmd.clear) begin
            r_clr_idx <= r_clr_idx + CIW'(1);
        end
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_type <= i_s_tuser;
            r_cl   <= in_cl;
            r_node <= i_s_tdata[cmt_pkg::IN_NODE_LSB +: 32];
            r_slot <= i_s_tdata[cmt_pkg::IN_SLOT_LSB +: 6];
        end
    end

    // count memory
    always_comb begin
        cnt_we = i_cmd.clear || i_cmd.commit_join || i_cmd.commit_leave;
        cnt_wa = i_cmd.clear ? r_clr_idx : cl_idx;
        if (i_cmd.clear) begin
            cnt_wd = '0;
        end else if (i_cmd.commit_join) begin
            cnt_wd = r_cnt_q + CW'(1);
        end else begin
            cnt_wd = r_cnt_q - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            cnt_mem[cnt_wa] <= cnt_wd;
        end
        if (i_cmd.accept) begin
            r_cnt_q <= cnt_mem[CIW'(in_cl)];
        end
    end

    // member memory: one write port, two read ports
    always_comb begin
        mem_we = i_cmd.commit_join || (i_cmd.commit_leave && (slot_sw != tail_sw));
        if (i_cmd.commit_join) begin
            mem_wa = {cl_idx, SW'(r_cnt_q)};
            mem_wd = r_node;
        end else begin
            mem_wa = {cl_idx, slot_sw};
            mem_wd = r_tail_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_mem[mem_wa] <= mem_wd;
        end
        if (i_cmd.rd_members) begin
            r_slot_q <= mem_mem[{cl_idx, slot_sw}];
            r_tail_q <= mem_mem[{cl_idx, tail_sw}];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_ok <= i_cmd.emit_ok;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(cmt_pkg::OUT_TDATA_W-1){1'b0}}, r_out_ok};

    always_comb begin
        o_sts.clear_done = (r_clr_idx == CIW'(CD - 1));
        o_sts.is_leave   = (r_type == cmt_pkg::REQ_LEAVE);
        o_sts.join_ok    = in_range && (W'(r_cnt_q) < W'(r_cap))
                           && (r_cnt_q < CW'(MAX_MEMBERS));
        o_sts.slot_ok    = in_range && (W'(r_slot) < W'(r_cnt_q));
        o_sts.id_match   = (r_slot_q == r_node);
        o_sts.out_free   = !r_out_valid || i_m_tready;
    end

endmodule

@@ hdl/cluster_membership_table.sv @@
// Cluster membership table.
// Requests enter on the slave stream: tuser[0] is the kind (0 join, 1 leave),
// tdata carries cluster id, node id and slot. Each request returns exactly
// one item on the master stream, tdata[0] = ok.
// A join appends the node to the cluster unless the count reached the
// capacity register (saturated to MAX_MEMBERS). A leave removes the slot if it
// is occupied and holds the given node, moving the last member into it.
// The result register loads in the evaluate state after accept for a join
// or a rejected leave, and in the check state after the member read for a
// leave that reads members. An item passes through the states idle,
// evaluate and, for a leave that reads members, check; a new item is taken
// only in idle, so one item is held at a time.
// Reset: the capacity goes to 64 and a clearing pass zeroes the count memory,
// one entry per cycle over all min(CLUSTER_CNT, 256) entries, with tready low.
// Capacity writes are taken at any time.
// Stall: a new item is accepted while a result waits; if the result register
// is still full when the next result is ready, the block holds that item
// and commits nothing until the receiver takes the old result.
module cluster_membership_table #(
    parameter int CLUSTER_CNT = 256,
    parameter int MAX_MEMBERS = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // request stream
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // [7:0] cluster, [39:8] node_id, [45:40] slot, [47:46] zero
    input  logic [cmt_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    // [0] req_type
    input  logic                            i_s_tuser,
    // result stream
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // [0] ok, [7:1] zero
    output logic [cmt_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    // capacity register
    input  logic                            i_cfg_wr_en,
    input  logic [cmt_pkg::CAP_W-1:0]       i_cfg_wr_data
);

    cmt_pkg::t_cmd    cmd;
    cmt_pkg::t_status sts;

    cmt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    cmt_datapath #(
        .CLUSTER_CNT (CLUSTER_CNT),
        .MAX_MEMBERS (MAX_MEMBERS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tdata     (i_s_tdata),
        .i_s_tuser     (i_s_tuser),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .o_m_tdata     (o_m_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_cmd         (cmd),
        .o_sts         (sts)
    );

endmodule

@@ tb/tb_cluster_membership_table.sv @@
module tb_cluster_membership_table;

    localparam int CLUSTERS    = 256;
    localparam int SLOTS       = 64;
    localparam int PHASE_ITEMS = 480;      // random items per idling phase
    localparam int HOLD_CYCLES = 200;      // long result back-pressure stretch
    localparam int SETTLE      = 20;       // tail wait after the last result
    localparam int CYCLE_LIMIT = 400000;
    // clusters hit often (after cluster 0) so that lists fill up, wrap and drain
    localparam logic [31:0] HOT_SET = {8'd255, 8'd128, 8'd127, 8'd1};

    // ------------------------------------------------------------------
    // Shadow of the membership table: per-cluster counts and member ids,
    // plus the capacity register. Every accepted request pushes the ok
    // flag it must produce; every result pops and compares.
    // ------------------------------------------------------------------
    class roster_model;
        logic [6:0]  count [CLUSTERS];
        logic [31:0] member_id [CLUSTERS][SLOTS];
        logic [6:0]  capacity;
        logic        ok_expected [$];
        int          ok_errors;

        function new();
            foreach (count[c]) count[c] = '0;
            capacity  = cmt_pkg::CAP_RESET;
            ok_errors = 0;
        endfunction

        function void set_capacity(logic [6:0] value);
            capacity = value;
        endfunction

        // capacity saturates at the list depth
        function int cap_limit();
            return (capacity > SLOTS) ? SLOTS : int'(capacity);
        endfunction

        function void apply_request(logic kind, logic [7:0] cl, logic [31:0] node,
                                    logic [5:0] slot);
            int   n;
            logic ok;
            n  = int'(count[cl]);
            ok = 1'b0;
            // cluster ids cannot exceed the table with 8 bits and 256 clusters
            if (kind == cmt_pkg::REQ_JOIN) begin
                if (n < cap_limit() && n < SLOTS) begin
                    member_id[cl][n] = node;
                    count[cl]        = 7'(n + 1);
                    ok               = 1'b1;
                end
            end else if (int'(slot) < n && member_id[cl][slot] == node) begin
                // tail moves into the freed slot (no-op when slot is the tail)
                member_id[cl][slot] = member_id[cl][n - 1];
                count[cl]           = 7'(n - 1);
                ok                  = 1'b1;
            end
            ok_expected.push_back(ok);
        endfunction

        function void check_ok(logic got);
            logic want;
            if (ok_expected.size() == 0) begin
                $display("%0t: result with nothing pending: expected none, actual ok=%b",
                         $time, got);
                ok_errors++;
                return;
            end
            want = ok_expected.pop_front();
            if (got !== want) begin
                $display("%0t: ok mismatch: expected %b, actual %b", $time, want, got);
                ok_errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT hookup; all inputs start at known values
    // ------------------------------------------------------------------
    logic                            clk         = 1'b0;
    logic                            rst_n       = 1'b0;
    logic                            s_tvalid    = 1'b0;
    logic                            s_tready;
    // [7:0] cl, [39:8] node, [45:40] slot
    logic [cmt_pkg::IN_TDATA_W-1:0]  s_tdata     = '0;
    logic                            s_tuser     = 1'b0; // [0] req kind
    logic                            m_tvalid;
    logic                            m_tready    = 1'b0;
    logic [cmt_pkg::OUT_TDATA_W-1:0] m_tdata;            // [0] ok
    logic                            cfg_wr_en   = 1'b0;
    logic [cmt_pkg::CAP_W-1:0]       cfg_wr_data = '0;

    roster_model roster = new();

    // idle odds in percent, set per phase by the stimulus process
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    logic        hold_request  = 1'b0;
    int unsigned cycle_count   = 0;

    cluster_membership_table #(
        .CLUSTER_CNT (CLUSTERS),
        .MAX_MEMBERS (SLOTS)
    ) i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_s_tvalid    (s_tvalid),
        .o_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_s_tuser     (s_tuser),
        .o_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .o_m_tdata     (m_tdata),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // hang guard: covers the clearing pass and the slowest idling phase
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** cluster_membership_table: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Result side: check at each edge, then pick tready for the next one.
    // A hold request turns into a long tready-low stretch counted here.
    // ------------------------------------------------------------------
    initial begin : result_sink
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                roster.check_ok(m_tdata[0]);
            if (hold_request) begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    // Offer one item, wait for the handshake, then log it in the model.
    // tvalid stays high on return so back-to-back items need no toggle.
    task automatic send_request(input logic kind, input logic [7:0] cl,
                                input logic [31:0] node, input logic [5:0] slot);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {2'b00, slot, node, cl};
        do @(posedge clk); while (!s_tready);
        roster.apply_request(kind, cl, node, slot);
    endtask

    // sender pause until every pending result is back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (roster.ok_expected.size() != 0);
    endtask

    // capacity changes only with the block idle
    task automatic write_capacity(input logic [6:0] value);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        roster.set_capacity(value);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic logic [7:0] pick_cluster();
        int r;
        int k;
        r = $urandom_range(99);
        k = $urandom_range(3);
        if (r < 45)
            return 8'd0;                    // the deep one: fills to the top
        if (r < 85)
            return HOT_SET[8*k +: 8];
        return 8'($urandom_range(255));
    endfunction

    // Mostly well-formed traffic: joins, and leaves that name a live slot
    // with its stored id. The rest are broken leaves: wrong id at a live
    // slot, or a random slot with random id (usually past the count).
    task automatic random_request(input int join_pct, input int good_leave_pct);
        int          roll;
        int          n;
        logic        kind;
        logic [7:0]  cl;
        logic [31:0] node;
        logic [5:0]  slot;
        roll = $urandom_range(99);
        cl   = pick_cluster();
        n    = int'(roster.count[cl]);
        node = $urandom();
        slot = 6'($urandom_range(63));     // also toggles the unused join field
        if (roll < join_pct) begin
            kind = cmt_pkg::REQ_JOIN;
        end else begin
            kind = cmt_pkg::REQ_LEAVE;
            if (n > 0 && roll < join_pct + good_leave_pct) begin
                slot = 6'($urandom_range(n - 1));
                node = roster.member_id[cl][slot];
            end else if (n > 0 && $urandom_range(1) == 1) begin
                slot = 6'($urandom_range(n - 1));
                node = roster.member_id[cl][slot] ^ (32'd1 << $urandom_range(31));
            end
        end
        send_request(kind, cl, node, slot);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        int p;
        int k;
        int join_pct;
        int leave_pct;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty list, id extremes, mismatch, bad slots,
        // move of the tail, leave of the tail itself (capacity at reset)
        send_request(cmt_pkg::REQ_LEAVE, 8'd0,   32'h0000_0000, 6'd0);
        send_request(cmt_pkg::REQ_JOIN,  8'd0,   32'hFFFF_FFFF, 6'd63);
        send_request(cmt_pkg::REQ_JOIN,  8'd0,   32'h0000_0000, 6'd0);
        send_request(cmt_pkg::REQ_JOIN,  8'd255, 32'hA5A5_A5A5, 6'd21);
        send_request(cmt_pkg::REQ_LEAVE, 8'd0,   32'h1234_5678, 6'd0);
        send_request(cmt_pkg::REQ_LEAVE, 8'd0,   32'h0000_0000, 6'd2);
        send_request(cmt_pkg::REQ_LEAVE, 8'd0,   32'hFFFF_FFFF, 6'd63);
        send_request(cmt_pkg::REQ_LEAVE, 8'd0,   32'hFFFF_FFFF, 6'd0);
        send_request(cmt_pkg::REQ_LEAVE, 8'd0,   32'h0000_0000, 6'd0);
        send_request(cmt_pkg::REQ_LEAVE, 8'd255, 32'hA5A5_A5A5, 6'd0);

        // capacity one: second join is full
        write_capacity(7'd1);
        send_request(cmt_pkg::REQ_JOIN,  8'd5,   32'h0000_0001, 6'd0);
        send_request(cmt_pkg::REQ_JOIN,  8'd5,   32'h0000_0002, 6'd0);

        // capacity zero: no join, leave still applies
        write_capacity(7'd0);
        send_request(cmt_pkg::REQ_JOIN,  8'd6,   32'h0000_0003, 6'd0);
        send_request(cmt_pkg::REQ_LEAVE, 8'd5,   32'h0000_0001, 6'd0);

        // capacity lowered under a live count
        write_capacity(7'd2);
        send_request(cmt_pkg::REQ_JOIN,  8'd10,  32'h0000_0010, 6'd0);
        send_request(cmt_pkg::REQ_JOIN,  8'd10,  32'h0000_0011, 6'd0);
        write_capacity(7'd1);
        send_request(cmt_pkg::REQ_JOIN,  8'd10,  32'h0000_0012, 6'd0);
        send_request(cmt_pkg::REQ_LEAVE, 8'd10,  32'h0000_0010, 6'd0);

        // capacity above the list depth saturates
        write_capacity(7'd127);
        send_request(cmt_pkg::REQ_JOIN,  8'd10,  32'h0000_0013, 6'd0);
        send_request(cmt_pkg::REQ_JOIN,  8'd128, 32'h8000_0000, 6'd42);

        // random phases: fast sender / slow receiver, then the reverse,
        // then full rate; each with one long receiver hold-off
        for (p = 0; p < 3; p++) begin
            case (p)
                0: begin
                    write_capacity(7'd127);
                    send_idle_pct = 8;
                    recv_idle_pct = 88;
                    join_pct      = 65;
                    leave_pct     = 20;
                end
                1: begin
                    write_capacity(7'd3);      // under most hot counts
                    send_idle_pct = 88;
                    recv_idle_pct = 8;
                    join_pct      = 30;
                    leave_pct     = 50;
                end
                default: begin
                    write_capacity(7'd64);
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    join_pct      = 45;
                    leave_pct     = 40;
                end
            endcase
            for (k = 0; k < PHASE_ITEMS; k++) begin
                if (k == PHASE_ITEMS / 3)
                    hold_request = 1'b1;
                random_request(join_pct, leave_pct);
            end
        end

        drain_results();
        repeat (SETTLE) @(posedge clk);
        if (roster.ok_errors == 0 && roster.ok_expected.size() == 0) begin
            $display("** cluster_membership_table: PASSED **");
        end else begin
            $display("** cluster_membership_table: FAILED **");
        end
        $finish;
    end

endmodule
